>>> design/mhpq_pkg.sv
// shared types and codes for the min-heap priority queue
package mhpq_pkg;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UP_CHK,
		ST_UP_CMP,
		ST_DN_FETCH,
		ST_DN_LOAD,
		ST_DN_CHK,
		ST_DN_FIRST,
		ST_DN_SEL,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		RD_PARENT,
		RD_LAST,
		RD_FIRST,
		RD_SECOND
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_CUR,
		WR_RDATA,
		WR_BEST
	} wr_sel_t;

	typedef enum logic [1:0] {
		POS_HOLD,
		POS_PARENT,
		POS_BEST,
		POS_ZERO
	} pos_sel_t;

	typedef struct packed {
		logic     ld_ins;
		logic     ld_rem;
		logic     set_full;
		logic     set_empty;
		logic     ld_cur;
		logic     ld_a;
		logic     rd_en;
		rd_sel_t  rd_sel;
		logic     wr_en;
		wr_sel_t  wr_sel;
		pos_sel_t pos_sel;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic pos_zero;
		logic cnt_zero;
		logic up_stop;
		logic first_absent;
		logic second_absent;
		logic dn_stop;
	} dp_status_t;

endpackage

>>> design/mhpq_ram.sv
// generic single write, single read ram with registered read data
module mhpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> design/mhpq_ctrl.sv
// controller state machine for heap insert and remove sequences
module mhpq_ctrl
	import mhpq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       op,
	input  dp_status_t st,
	output logic       busy,
	output logic       done,
	output cmd_t       cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.rd_sel  = RD_PARENT;
		cmd.wr_sel  = WR_CUR;
		cmd.pos_sel = POS_HOLD;
		busy        = 1'b1;
		done        = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (op == OP_INSERT) begin
						if (st.full) begin
							cmd.set_full = 1'b1;
							state_d      = ST_DONE;
						end else begin
							cmd.ld_ins = 1'b1;
							state_d    = ST_UP_CHK;
						end
					end else begin
						if (st.empty) begin
							cmd.set_empty = 1'b1;
							state_d       = ST_DONE;
						end else begin
							cmd.ld_rem = 1'b1;
							state_d    = ST_DN_FETCH;
						end
					end
				end
			end
			ST_UP_CHK: begin
				if (st.pos_zero) begin
					cmd.wr_en = 1'b1;
					state_d   = ST_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PARENT;
					state_d    = ST_UP_CMP;
				end
			end
			ST_UP_CMP: begin
				cmd.wr_en = 1'b1;
				if (st.up_stop) begin
					state_d = ST_DONE;
				end else begin
					cmd.wr_sel  = WR_RDATA;
					cmd.pos_sel = POS_PARENT;
					state_d     = ST_UP_CHK;
				end
			end
			ST_DN_FETCH: begin
				if (st.cnt_zero) begin
					state_d = ST_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_LAST;
					state_d    = ST_DN_LOAD;
				end
			end
			ST_DN_LOAD: begin
				cmd.ld_cur  = 1'b1;
				cmd.pos_sel = POS_ZERO;
				state_d     = ST_DN_CHK;
			end
			ST_DN_CHK: begin
				if (st.first_absent) begin
					cmd.wr_en = 1'b1;
					state_d   = ST_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_FIRST;
					state_d    = ST_DN_FIRST;
				end
			end
			ST_DN_FIRST: begin
				cmd.ld_a = 1'b1;
				if (!st.second_absent) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_SECOND;
				end
				state_d = ST_DN_SEL;
			end
			ST_DN_SEL: begin
				cmd.wr_en = 1'b1;
				if (st.dn_stop) begin
					state_d = ST_DONE;
				end else begin
					cmd.wr_sel  = WR_BEST;
					cmd.pos_sel = POS_BEST;
					state_d     = ST_DN_CHK;
				end
			end
			ST_DONE: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> design/mhpq_dp.sv
// heap datapath: key store, moving key, position, fill count and result registers
module mhpq_dp
	import mhpq_pkg::*;
#(
	parameter int CAPACITY = 1024,
	parameter int KEY_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] key,
	input  cmd_t        cmd,
	output dp_status_t  st,
	output logic [31:0] top_key,
	output logic        top_valid,
	output logic [10:0] fill_count,
	output logic [1:0]  status
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = AW + 2;

	logic [CW-1:0]       cnt_q;
	logic [AW-1:0]       pos_q;
	logic [KEY_BITS-1:0] cur_q;
	logic [KEY_BITS-1:0] a_q;
	logic [KEY_BITS-1:0] top_q;
	logic                has2_q;
	logic [1:0]          status_q;

	logic [KEY_BITS-1:0] rdata;
	logic [KEY_BITS-1:0] wdata;
	logic [KEY_BITS-1:0] best_val;
	logic [KEY_BITS-1:0] cand_val;
	logic [AW-1:0]       raddr;
	logic [AW-1:0]       parent;
	logic [AW-1:0]       best_idx;
	logic [XW-1:0]       first;
	logic [XW-1:0]       second;
	logic [XW-1:0]       cnt_x;
	logic                a_lt;
	logic                b_lt;

	assign parent = (pos_q - AW'(1)) >> 1;
	assign first  = {1'b0, pos_q, 1'b1};
	assign second = first + XW'(1);
	assign cnt_x  = XW'(cnt_q);

	assign a_lt     = a_q < cur_q;
	assign cand_val = a_lt ? a_q : cur_q;
	assign b_lt     = has2_q && (rdata < cand_val);
	assign best_idx = b_lt ? second[AW-1:0] : first[AW-1:0];
	assign best_val = b_lt ? rdata : a_q;

	assign st.full          = cnt_q == CW'(CAPACITY);
	assign st.empty         = cnt_q == '0;
	assign st.pos_zero      = pos_q == '0;
	assign st.cnt_zero      = cnt_q == '0;
	assign st.up_stop       = rdata <= cur_q;
	assign st.first_absent  = first >= cnt_x;
	assign st.second_absent = second >= cnt_x;
	assign st.dn_stop       = !a_lt && !b_lt;

	always_comb begin
		case (cmd.rd_sel)
			RD_PARENT: raddr = parent;
			RD_LAST:   raddr = cnt_q[AW-1:0];
			RD_FIRST:  raddr = first[AW-1:0];
			RD_SECOND: raddr = second[AW-1:0];
			default:   raddr = parent;
		endcase
	end

	always_comb begin
		case (cmd.wr_sel)
			WR_CUR:   wdata = cur_q;
			WR_RDATA: wdata = rdata;
			WR_BEST:  wdata = best_val;
			default:  wdata = cur_q;
		endcase
	end

	mhpq_ram #(
		.WIDTH(KEY_BITS),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(pos_q),
		.wdata(wdata),
		.re   (cmd.rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			status_q <= STATUS_OK;
		end else begin
			if (cmd.ld_ins) begin
				cnt_q    <= cnt_q + CW'(1);
				status_q <= STATUS_OK;
			end
			if (cmd.ld_rem) begin
				cnt_q    <= cnt_q - CW'(1);
				status_q <= STATUS_OK;
			end
			if (cmd.set_full) begin
				status_q <= STATUS_FULL;
			end
			if (cmd.set_empty) begin
				status_q <= STATUS_EMPTY;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_ins) begin
			cur_q <= KEY_BITS'(key);
			pos_q <= cnt_q[AW-1:0];
		end else begin
			case (cmd.pos_sel)
				POS_HOLD:   pos_q <= pos_q;
				POS_PARENT: pos_q <= parent;
				POS_BEST:   pos_q <= best_idx;
				POS_ZERO:   pos_q <= '0;
				default:    pos_q <= pos_q;
			endcase
		end
		if (cmd.ld_cur) begin
			cur_q <= rdata;
		end
		if (cmd.ld_a) begin
			a_q    <= rdata;
			has2_q <= !st.second_absent;
		end
		if (cmd.wr_en && pos_q == '0) begin
			top_q <= wdata;
		end
	end

	assign top_valid  = cnt_q != '0;
	assign top_key    = top_valid ? 32'(top_q) : 32'd0;
	assign fill_count = 11'(cnt_q);
	assign status     = status_q;

endmodule

>>> design/min_heap_priority_queue_top.sv
// top level of the min-heap priority queue
//
// command channel: a word (op, key) is taken at a rising edge with start high
// and busy low. op insert appends key and sifts it up, op remove drops the
// smallest key and sifts the last entry down from the root.
// result channel: done is high for one cycle with top_key, top_valid,
// fill_count and status; the result must be taken in that cycle, the
// receiver cannot stall it. busy stays high from acceptance until done.
// each heap level the key moves through (at most log2 of CAPACITY) needs
// one or two reads of the key store through its single registered read
// port, a compare and a write.
// a refused insert on a full heap or a remove on an empty heap sets status
// and goes straight to done; a remove of the last key skips the sift down.
// reset idles the controller and clears the fill count and status only;
// store entries are not cleared, since only entries below the fill count
// held at acceptance are ever read.
module min_heap_priority_queue_top
	import mhpq_pkg::*;
#(
	parameter int CAPACITY = 1024,
	parameter int KEY_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        op,
	input  logic [31:0] key,
	output logic        done,
	output logic [31:0] top_key,
	output logic        top_valid,
	output logic [10:0] fill_count,
	output logic [1:0]  status
);

	cmd_t       cmd;
	dp_status_t st;

	mhpq_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.op    (op),
		.st    (st),
		.busy  (busy),
		.done  (done),
		.cmd   (cmd)
	);

	mhpq_dp #(
		.CAPACITY(CAPACITY),
		.KEY_BITS(KEY_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.key       (key),
		.cmd       (cmd),
		.st        (st),
		.top_key   (top_key),
		.top_valid (top_valid),
		.fill_count(fill_count),
		.status    (status)
	);

endmodule
